@@ rtl/core/pett_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pett_pkg: shared types and constants
// Request and result payloads, codes and the slot-count default.
// ----------------------------------------------------------------------------
package pett_pkg;

   localparam int SLOTS_DEFAULT = 16;
   localparam int MAX_RESULTS   = 16;

   localparam logic [1:0] REQ_TICK   = 2'd0;
   localparam logic [1:0] REQ_ADD    = 2'd1;
   localparam logic [1:0] REQ_REMOVE = 2'd2;
   localparam logic [1:0] REQ_NONE   = 2'd3;

   localparam logic [1:0] KIND_ACCEPT = 2'd0;
   localparam logic [1:0] KIND_REJECT = 2'd1;
   localparam logic [1:0] KIND_FIRED  = 2'd2;
   localparam logic [1:0] KIND_IDLE   = 2'd3;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [31:0] now_us;
      logic [7:0]  handler_id;
      logic [31:0] period_us;
   } req_type_type;

   typedef struct packed {
      logic [1:0] result_kind;
      logic [7:0] fired_handler;
      logic [3:0] fired_slot;
      logic       last_of_run;
   } rsp_type;

   // one table entry as stored in memory
   typedef struct packed {
      logic [7:0]  handler;
      logic [31:0] period;
      logic [31:0] stamp;
   } entry_type;

endpackage

@@ rtl/core/pett_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pett_ram: generic single-port-write, single-read RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module pett_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                           clock,
   input  logic                                           wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                               wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                               rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

@@ rtl/core/periodic_event_timer_table_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_event_timer_table_core: ordered table of periodic events
// Add and remove edit the table, a tick scans it and reports due events.
// ----------------------------------------------------------------------------
// Sequence: add writes the entry and goes to S_DONE; remove and tick pass
//   S_READ then S_EVAL for each stored entry scanned, then S_DONE.
// Throughput: one item at a time; busy is high until the last result.
// Results: one strobe per cycle on rsp_valid; the receiver cannot stall.
// Reset: entry count, started flag and enable cleared; table RAM is not
//   cleared (entries are only read below the entry count).
// ----------------------------------------------------------------------------
module periodic_event_timer_table_core #(
   parameter int SLOTS = pett_pkg::SLOTS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  pett_pkg::req_type_type req_data,
   output logic                   rsp_valid,
   output pett_pkg::rsp_type      rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic                   csr_data
);

   localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW = $clog2(SLOTS + 1);
   localparam int RW = $clog2(pett_pkg::MAX_RESULTS + 1);

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_READ  = 6'b000010,  // address issued, wait for data
      S_EVAL  = 6'b000100,  // data available, decide and write back
      S_SHIFT = 6'b001000,  // unused; remove copies entry i+1 to i in S_EVAL
      S_DONE  = 6'b010000,  // emit the closing result
      S_EMPTY = 6'b100000   // unused
   } state_type;

   state_type              state_ff, state_in;
   pett_pkg::req_type_type req_ff, req_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [CW-1:0]          idx_ff, idx_in;
   logic [RW-1:0]          nres_ff, nres_in;
   logic                   enable_ff, enable_in;
   logic                   started_ff, started_in;
   logic                   init_ff, init_in;   // first tick: load the stamps
   logic                   found_ff, found_in;
   logic [1:0]             done_kind_ff, done_kind_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   pett_pkg::rsp_type      rsp_ff, rsp_in;

   logic                   wr_en;
   logic [AW-1:0]          wr_addr, rd_addr;
   pett_pkg::entry_type    wr_data, rd_data;
   logic                   accept;
   logic [31:0]            base_stamp, elapsed;
   logic [AW-1:0]          idx_a;

   pett_ram #(.WIDTH($bits(pett_pkg::entry_type)), .DEPTH(SLOTS)) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign busy       = (state_ff != S_IDLE);
   assign accept     = start && !busy;
   assign csr_ready  = 1'b1;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;
   assign idx_a      = idx_ff[AW-1:0];
   assign base_stamp = init_ff ? req_ff.now_us : rd_data.stamp;
   assign elapsed    = req_ff.now_us - base_stamp;

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      nres_in      = nres_ff;
      enable_in    = enable_ff;
      started_in   = started_ff;
      init_in      = init_ff;
      found_in     = found_ff;
      done_kind_in = done_kind_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      wr_addr      = idx_a;
      wr_data      = rd_data;
      rd_addr      = idx_a;

      // config writes must arrive only while idle; the block does not enforce it
      if (csr_valid) begin
         enable_in = csr_data;
         if (!csr_data) begin
            started_in = 1'b0;
         end
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               req_in   = req_data;
               idx_in   = '0;
               nres_in  = '0;
               found_in = 1'b0;
               rd_addr  = '0;
               unique case (req_data.req_type)
                  pett_pkg::REQ_ADD: begin
                     if (count_ff >= CW'(SLOTS)) begin
                        done_kind_in = pett_pkg::KIND_REJECT;
                     end else begin
                        wr_en        = 1'b1;
                        wr_addr      = count_ff[AW-1:0];
                        wr_data      = '{req_data.handler_id, req_data.period_us,
                                         req_data.now_us};
                        count_in     = count_ff + 1'b1;
                        done_kind_in = pett_pkg::KIND_ACCEPT;
                     end
                     state_in = S_DONE;
                  end
                  pett_pkg::REQ_REMOVE: begin
                     done_kind_in = pett_pkg::KIND_REJECT;
                     state_in     = (count_ff == '0) ? S_DONE : S_READ;
                  end
                  pett_pkg::REQ_TICK: begin
                     done_kind_in = pett_pkg::KIND_IDLE;
                     if (!enable_ff) begin
                        started_in = 1'b0;
                        state_in   = S_DONE;
                     end else begin
                        init_in    = !started_ff;
                        started_in = 1'b1;
                        state_in   = (count_ff == '0) ? S_DONE : S_READ;
                     end
                  end
                  default: begin
                     done_kind_in = pett_pkg::KIND_REJECT;
                     state_in     = S_DONE;
                  end
               endcase
            end
         end
         S_READ: begin
            state_in = S_EVAL;
         end
         S_EVAL: begin
            if (req_ff.req_type == pett_pkg::REQ_REMOVE) begin
               if (found_ff) begin
                  // shifting: write entry read at idx into idx-1
                  wr_en   = 1'b1;
                  wr_addr = AW'(idx_ff - 1'b1);
                  wr_data = rd_data;
               end else if (rd_data.handler == req_ff.handler_id &&
                            rd_data.period == req_ff.period_us) begin
                  found_in     = 1'b1;
                  done_kind_in = pett_pkg::KIND_ACCEPT;
               end
               if (idx_ff + 1'b1 >= count_ff) begin
                  if (found_in) begin
                     count_in = count_ff - 1'b1;
                  end
                  state_in = S_DONE;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  rd_addr  = AW'(idx_ff + 1'b1);
                  state_in = S_READ;
               end
            end else begin
               // tick: evaluate slot idx
               wr_en   = 1'b1;
               wr_data = '{rd_data.handler, rd_data.period, base_stamp};
               if (nres_ff < RW'(pett_pkg::MAX_RESULTS) &&
                   elapsed >= rd_data.period) begin
                  wr_data.stamp = base_stamp + rd_data.period;
                  rsp_valid_in  = 1'b1;
                  rsp_in        = '{pett_pkg::KIND_FIRED, rd_data.handler,
                                    4'(idx_ff), 1'b0};
                  nres_in       = nres_ff + 1'b1;
               end
               if (idx_ff + 1'b1 >= count_ff) begin
                  init_in  = 1'b0;
                  state_in = S_DONE;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  rd_addr  = AW'(idx_ff + 1'b1);
                  state_in = S_READ;
               end
            end
         end
         S_DONE: begin
            // fired results mark last via a trailing flag: hold one pending
            rsp_valid_in = 1'b1;
            if (req_ff.req_type == pett_pkg::REQ_TICK && nres_ff != '0) begin
               rsp_valid_in = 1'b0;
            end
            rsp_in   = '{done_kind_ff, 8'd0, 4'd0, 1'b1};
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Each fired result is held here until the next fired result or S_DONE
   // releases it, so the final one can carry last_of_run.
   logic              pend_ff, pend_in;
   pett_pkg::rsp_type pend_rsp_ff, pend_rsp_in;
   logic              out_v;
   pett_pkg::rsp_type out_r;

   always_comb begin
      pend_in     = pend_ff;
      pend_rsp_in = pend_rsp_ff;
      out_v       = 1'b0;
      out_r       = rsp_in;
      if (rsp_valid_in && rsp_in.result_kind == pett_pkg::KIND_FIRED) begin
         // release previous, hold the new one
         out_v       = pend_ff;
         out_r       = pend_rsp_ff;
         pend_in     = 1'b1;
         pend_rsp_in = rsp_in;
      end else if (state_ff == S_DONE && pend_ff) begin
         out_v            = 1'b1;
         out_r            = pend_rsp_ff;
         out_r.last_of_run = 1'b1;
         pend_in          = 1'b0;
      end else if (rsp_valid_in) begin
         out_v = 1'b1;
         out_r = rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         enable_ff    <= 1'b0;
         started_ff   <= 1'b0;
         init_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         enable_ff    <= enable_in;
         started_ff   <= started_in;
         init_ff      <= init_in;
         rsp_valid_ff <= out_v;
         pend_ff      <= pend_in;
      end
      req_ff       <= req_in;
      idx_ff       <= idx_in;
      nres_ff      <= nres_in;
      found_ff     <= found_in;
      done_kind_ff <= done_kind_in;
      rsp_ff       <= out_r;
      pend_rsp_ff  <= pend_rsp_in;
   end

endmodule
